[rtl/tar_pkg.sv]
// Shared types and constants for the tensor axis reducer.
package tar_pkg;

    // Element and result width.
    localparam int DATA_W = 32;

    // Row number width and the width of the column count register.
    localparam int ROW_W = 16;
    localparam int COLCNT_W = 11;

    // Output queue depth and its pointer width.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;

    // Reduction codes as written to the op register.
    typedef enum logic [2:0] {
        OP_MAX   = 3'd0,
        OP_MIN   = 3'd1,
        OP_SUM   = 3'd2,
        OP_SUMSQ = 3'd3,
        OP_L1    = 3'd4
    } op_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        CFG_OP     = 3'd0,
        CFG_LAYOUT = 3'd1,
        CFG_ROWS   = 3'd2,
        CFG_COLS   = 3'd3,
        CFG_SCALE  = 3'd4
    } cfg_idx_t;

    // Layout codes.
    localparam logic LAYOUT_ROW = 1'b0;
    localparam logic LAYOUT_COL = 1'b1;

    // One queued result.
    typedef struct packed {
        logic              last;
        logic [ROW_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } result_t;

endpackage

[rtl/tensor_axis_reducer_core.sv]
// Row-wise or column-wise max/min/sum/sum-of-squares/L1 reducer with scaling.
// A result passes stage 1, stage 2 and the output queue before it is offered on m_axis.
// Throughput: one element per cycle while s_axis_tready is high; the column accumulator
// memory is read at acceptance, written back the next cycle, with forwarding between neighbors.
// s_axis_tready drops only when four results are pending downstream.
// Reset (rst_n, asynchronous): control registers reset; data registers and memory do not.
module tensor_axis_reducer_core #(
    parameter int MAX_COLS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port.
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [tar_pkg::DATA_W-1:0] cfg_data,
    // Input stream.
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // [31:0] sample_value
    // Output stream.
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [47:0]               m_axis_tdata,   // [31:0] result_value, [47:32] result_index
    output logic                      m_axis_tlast    // final_flag
);

    localparam int CPOS_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [16:0] MAX_COLS_EXT = 17'(MAX_COLS);
    localparam logic [CPOS_W-1:0] ADDR_MASK = CPOS_W'(MAX_COLS - 1);

    // Configuration registers.
    logic [2:0]                        reduce_op_reg;
    logic                              reduce_layout_reg;
    logic [tar_pkg::ROW_W-1:0]         row_count_reg;
    logic [tar_pkg::COLCNT_W-1:0]      col_count_reg;
    logic [tar_pkg::DATA_W-1:0]        scale_reg;

    // Matrix position.
    logic [tar_pkg::ROW_W-1:0]         row_pos_reg;
    logic [CPOS_W-1:0]                 col_pos_reg;

    // Stage 1: mapped element and its bookkeeping.
    logic                              s1_valid_reg;
    logic [tar_pkg::DATA_W-1:0]        s1_value_reg;
    logic                              s1_first_reg;
    logic                              s1_emit_reg;
    logic [tar_pkg::ROW_W-1:0]         s1_index_reg;
    logic                              s1_last_reg;
    logic [CPOS_W-1:0]                 s1_addr_reg;
    logic                              s1_fwd_reg;

    // Stage 2: folded accumulator value.
    logic                              s2_valid_reg;
    logic [tar_pkg::DATA_W-1:0]        fold_reg;
    logic [tar_pkg::ROW_W-1:0]         s2_index_reg;
    logic                              s2_last_reg;

    // Column accumulator memory.
    logic [tar_pkg::DATA_W-1:0]        acc_mem [MAX_COLS];
    logic [tar_pkg::DATA_W-1:0]        rdata_reg;

    // Output queue.
    tar_pkg::result_t                  out_q [tar_pkg::OUT_DEPTH];
    logic [tar_pkg::OUT_PTR_W-1:0]     wr_ptr_reg;
    logic [tar_pkg::OUT_PTR_W-1:0]     rd_ptr_reg;
    logic [tar_pkg::OUT_PTR_W:0]       q_count_reg;
    logic [tar_pkg::OUT_PTR_W:0]       pending_reg;
    logic [tar_pkg::OUT_PTR_W:0]       q_count_next;
    logic [tar_pkg::OUT_PTR_W:0]       pending_next;

    // Decoded settings and position flags.
    tar_pkg::op_t                      op_eff;
    logic [tar_pkg::ROW_W-1:0]         rows_eff;
    logic [16:0]                       cols_eff;
    logic                              col_last;
    logic                              row_last;
    logic                              in_accept;
    logic                              out_accept;
    logic [CPOS_W-1:0]                 addr_in;
    logic [tar_pkg::DATA_W-1:0]        mapped;
    logic                              in_emit;
    logic                              in_first;
    logic [tar_pkg::ROW_W-1:0]         in_index;
    logic                              in_last;
    logic [tar_pkg::DATA_W-1:0]        old_acc;
    logic [tar_pkg::DATA_W-1:0]        fold_next;
    logic [tar_pkg::DATA_W-1:0]        product;
    logic                              cfg_hit;

    // Effective op, row and column counts.
    always_comb
    begin
        op_eff = (reduce_op_reg > 3'(tar_pkg::OP_L1)) ? tar_pkg::OP_SUM
                                                      : tar_pkg::op_t'(reduce_op_reg);
        rows_eff = (row_count_reg == '0) ? tar_pkg::ROW_W'(1) : row_count_reg;
        if (col_count_reg == '0)
        begin
            cols_eff = 17'd1;
        end
        else if (17'(col_count_reg) > MAX_COLS_EXT)
        begin
            cols_eff = MAX_COLS_EXT;
        end
        else
        begin
            cols_eff = 17'(col_count_reg);
        end
    end

    assign col_last = (17'(col_pos_reg) == (cols_eff - 17'd1));
    assign row_last = (row_pos_reg == (rows_eff - tar_pkg::ROW_W'(1)));
    assign addr_in = col_pos_reg & ADDR_MASK;

    assign s_axis_tready = (pending_reg < (tar_pkg::OUT_PTR_W + 1)'(tar_pkg::OUT_DEPTH));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    // Element mapping: identity, square or absolute value, all wrapping.
    always_comb
    begin
        case (op_eff)
            tar_pkg::OP_SUMSQ:
            begin
                mapped = 32'(s_axis_tdata * s_axis_tdata);
            end
            tar_pkg::OP_L1:
            begin
                mapped = s_axis_tdata[31] ? (32'd0 - s_axis_tdata) : s_axis_tdata;
            end
            default:
            begin
                mapped = s_axis_tdata;
            end
        endcase
    end

    // Per-layout control for the accepted element.
    always_comb
    begin
        if (reduce_layout_reg == tar_pkg::LAYOUT_ROW)
        begin
            in_first = (col_pos_reg == '0);
            in_emit  = col_last;
            in_index = row_pos_reg;
            in_last  = row_last;
        end
        else
        begin
            in_first = (row_pos_reg == '0);
            in_emit  = row_last;
            in_index = tar_pkg::ROW_W'(col_pos_reg);
            in_last  = col_last;
        end
    end

    // Fold of stage 1 against the row accumulator, the memory or the forwarded value.
    always_comb
    begin
        if (reduce_layout_reg == tar_pkg::LAYOUT_ROW || s1_fwd_reg)
        begin
            old_acc = fold_reg;
        end
        else
        begin
            old_acc = rdata_reg;
        end
        if (s1_first_reg)
        begin
            fold_next = s1_value_reg;
        end
        else
        begin
            case (op_eff)
                tar_pkg::OP_MAX:
                begin
                    fold_next = ($signed(old_acc) < $signed(s1_value_reg)) ? s1_value_reg
                                                                           : old_acc;
                end
                tar_pkg::OP_MIN:
                begin
                    fold_next = ($signed(s1_value_reg) < $signed(old_acc)) ? s1_value_reg
                                                                           : old_acc;
                end
                default:
                begin
                    fold_next = old_acc + s1_value_reg;
                end
            endcase
        end
    end

    // Scaled result, wrapped to the data width.
    assign product = 32'(fold_reg * scale_reg);

    // Configuration writes; a write to a known register restarts the matrix.
    assign cfg_hit = cfg_we && (cfg_index <= 3'(tar_pkg::CFG_SCALE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduce_op_reg     <= 3'(tar_pkg::OP_SUM);
            reduce_layout_reg <= tar_pkg::LAYOUT_ROW;
            row_count_reg     <= tar_pkg::ROW_W'(1);
            col_count_reg     <= tar_pkg::COLCNT_W'(1);
            scale_reg         <= tar_pkg::DATA_W'(1);
            row_pos_reg       <= '0;
            col_pos_reg       <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                tar_pkg::CFG_OP:     reduce_op_reg     <= cfg_data[2:0];
                tar_pkg::CFG_LAYOUT: reduce_layout_reg <= cfg_data[0];
                tar_pkg::CFG_ROWS:   row_count_reg     <= cfg_data[tar_pkg::ROW_W-1:0];
                tar_pkg::CFG_COLS:   col_count_reg     <= cfg_data[tar_pkg::COLCNT_W-1:0];
                tar_pkg::CFG_SCALE:  scale_reg         <= cfg_data;
                default:             scale_reg         <= scale_reg;
            endcase
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (in_accept)
        begin
            if (col_last)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= row_last ? '0 : (row_pos_reg + tar_pkg::ROW_W'(1));
            end
            else
            begin
                col_pos_reg <= col_pos_reg + CPOS_W'(1);
            end
        end
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_value_reg <= mapped;
            s1_first_reg <= in_first;
            s1_emit_reg  <= in_emit;
            s1_index_reg <= in_index;
            s1_last_reg  <= in_last;
            s1_addr_reg  <= addr_in;
            // The element in stage 1 writes this entry on the same edge as this read.
            s1_fwd_reg   <= s1_valid_reg && (s1_addr_reg == addr_in);
        end
        if (s1_valid_reg)
        begin
            fold_reg     <= fold_next;
            s2_index_reg <= s1_index_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Column accumulator memory: read at acceptance, written back from stage 1.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rdata_reg <= acc_mem[addr_in];
        end
        if (s1_valid_reg && reduce_layout_reg == tar_pkg::LAYOUT_COL)
        begin
            acc_mem[s1_addr_reg] <= fold_next;
        end
    end

    // Output queue storage.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            out_q[wr_ptr_reg] <= '{last: s2_last_reg, index: s2_index_reg, value: product};
        end
    end

    // Queue occupancy and the count of results promised but not yet taken.
    always_comb
    begin
        q_count_next = q_count_reg;
        pending_next = pending_reg;
        if (s2_valid_reg)
        begin
            q_count_next = q_count_next + (tar_pkg::OUT_PTR_W + 1)'(1);
        end
        if (out_accept)
        begin
            q_count_next = q_count_next - (tar_pkg::OUT_PTR_W + 1)'(1);
            pending_next = pending_next - (tar_pkg::OUT_PTR_W + 1)'(1);
        end
        if (in_accept && in_emit)
        begin
            pending_next = pending_next + (tar_pkg::OUT_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (s2_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + tar_pkg::OUT_PTR_W'(1);
            end
            if (out_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + tar_pkg::OUT_PTR_W'(1);
            end
            q_count_reg <= q_count_next;
            pending_reg <= pending_next;
        end
    end

    // Output transaction from the queue head.
    assign m_axis_tvalid = (q_count_reg != '0);
    assign m_axis_tdata  = {out_q[rd_ptr_reg].index, out_q[rd_ptr_reg].value};
    assign m_axis_tlast  = out_q[rd_ptr_reg].last;

endmodule

[bench/tb_tensor_axis_reducer_core.sv]
// Self-checking testbench for the tensor axis reducer core.
`timescale 1ns / 1ps

module tb_tensor_axis_reducer_core;

    localparam int MAX_COLS = 1024;
    localparam int RANDOM_ITEMS = 750;
    // Cycles to let pass after the last result before the block counts as idle.
    localparam int IDLE_GUARD = 8;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // Op codes outside the defined set; the block treats them as a sum.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    // Register indexes that select no register.
    localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CFG_SPARE_LAST = 3'd7;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [2:0]                   cfg_index = 3'd0;
    logic [tar_pkg::DATA_W-1:0]   cfg_data = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [31:0]                  s_axis_tdata = '0;    // [31:0] sample_value
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [47:0]                  m_axis_tdata;         // [31:0] result_value, [47:32] result_index
    logic                         m_axis_tlast;         // final_flag

    // Predictor copy of the registers and the reduction state.
    logic [2:0]                   reg_op;
    logic                         reg_layout;
    logic [tar_pkg::ROW_W-1:0]    reg_rows;
    logic [tar_pkg::COLCNT_W-1:0] reg_cols;
    logic [tar_pkg::DATA_W-1:0]   reg_scale;
    logic [tar_pkg::DATA_W-1:0]   row_acc;
    logic [tar_pkg::DATA_W-1:0]   col_acc [MAX_COLS];
    int unsigned                  row_pos;
    int unsigned                  col_pos;

    tar_pkg::result_t             pending_reductions[$];
    tar_pkg::result_t             oldest;

    int                           burst_left = 0;
    int                           items_sent = 0;
    int                           results_seen = 0;
    int                           register_writes = 0;
    int                           error_count = 0;

    tensor_axis_reducer_core #(
        .MAX_COLS(MAX_COLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Effective matrix sizes after the zero and overflow rules.
    function automatic int unsigned eff_rows();
        return (reg_rows == 0) ? 1 : int'(reg_rows);
    endfunction

    function automatic int unsigned eff_cols();
        if (reg_cols == 0)
            return 1;
        return (reg_cols > MAX_COLS) ? MAX_COLS : int'(reg_cols);
    endfunction

    // Element map: identity, wrapped square, or absolute value (most negative stays).
    function automatic logic [tar_pkg::DATA_W-1:0] map_sample(tar_pkg::op_t op,
                                                              logic [tar_pkg::DATA_W-1:0] v);
        case (op)
            tar_pkg::OP_SUMSQ: return v * v;
            tar_pkg::OP_L1:    return v[tar_pkg::DATA_W-1] ? -v : v;
            default:           return v;
        endcase
    endfunction

    // Fold one mapped element into an accumulator.
    function automatic logic [tar_pkg::DATA_W-1:0] fold_sample(tar_pkg::op_t op,
                                                               logic [tar_pkg::DATA_W-1:0] acc,
                                                               logic [tar_pkg::DATA_W-1:0] v);
        case (op)
            tar_pkg::OP_MAX: return ($signed(acc) < $signed(v)) ? v : acc;
            tar_pkg::OP_MIN: return ($signed(v) < $signed(acc)) ? v : acc;
            default:         return acc + v;
        endcase
    endfunction

    function automatic void reset_predictor();
        reg_op = 3'(tar_pkg::OP_SUM);
        reg_layout = tar_pkg::LAYOUT_ROW;
        reg_rows = tar_pkg::ROW_W'(1);
        reg_cols = tar_pkg::COLCNT_W'(1);
        reg_scale = tar_pkg::DATA_W'(1);
        row_acc = '0;
        row_pos = 0;
        col_pos = 0;
    endfunction

    // Update the predictor for one accepted element and queue any result it completes.
    function automatic void predict_reduction(logic [tar_pkg::DATA_W-1:0] sample);
        tar_pkg::op_t               op;
        int unsigned                rows;
        int unsigned                cols;
        logic [tar_pkg::DATA_W-1:0] mapped;
        logic [tar_pkg::DATA_W-1:0] acc;
        tar_pkg::result_t           res;
        op = (reg_op > 3'(tar_pkg::OP_L1)) ? tar_pkg::OP_SUM : tar_pkg::op_t'(reg_op);
        rows = eff_rows();
        cols = eff_cols();
        mapped = map_sample(op, sample);
        if (reg_layout == tar_pkg::LAYOUT_ROW)
        begin
            row_acc = (col_pos == 0) ? mapped : fold_sample(op, row_acc, mapped);
            if (col_pos == cols - 1)
            begin
                res.value = row_acc * reg_scale;
                res.index = 16'(row_pos);
                res.last = (row_pos == rows - 1);
                pending_reductions.push_back(res);
            end
        end
        else
        begin
            acc = (row_pos == 0) ? mapped : fold_sample(op, col_acc[col_pos], mapped);
            col_acc[col_pos] = acc;
            if (row_pos == rows - 1)
            begin
                res.value = acc * reg_scale;
                res.index = 16'(col_pos);
                res.last = (col_pos == cols - 1);
                pending_reductions.push_back(res);
            end
        end
        // Advance through the matrix in memory order, wrapping at its end.
        col_pos++;
        if (col_pos >= cols)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows)
                row_pos = 0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Write one register; a valid index restarts the matrix.
    task automatic write_register(input logic [2:0] idx,
                                  input logic [tar_pkg::DATA_W-1:0] data);
        bit known;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        known = 1'b1;
        case (idx)
            tar_pkg::CFG_OP:     reg_op = data[2:0];
            tar_pkg::CFG_LAYOUT: reg_layout = data[0];
            tar_pkg::CFG_ROWS:   reg_rows = data[tar_pkg::ROW_W-1:0];
            tar_pkg::CFG_COLS:   reg_cols = data[tar_pkg::COLCNT_W-1:0];
            tar_pkg::CFG_SCALE:  reg_scale = data;
            default:             known = 1'b0;
        endcase
        if (known)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        register_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one element, with random gaps between bursts, and wait for the transaction.
    task automatic send_sample(input logic [31:0] sample);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_reduction(sample);
        items_sent++;
    endtask

    // Stop offering and hold off until every expected result is out.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_reductions.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    // Random element with extra weight on the extremes and small magnitudes.
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return 32'($urandom_range(0, 32)) - 32'd16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd0;
            4, 5:    return 32'd1;
            6, 7:    return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: ready pattern changes between free flow, light and heavy stalls.
    initial
    begin : sink_stall
        int mode;
        int span;
        wait (rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_reductions.size() == 0)
                report_mismatch($sformatf("unexpected result value %h index %0d",
                                          m_axis_tdata[31:0], m_axis_tdata[47:32]));
            else
            begin
                oldest = pending_reductions.pop_front();
                if (m_axis_tdata[31:0] !== oldest.value)
                    report_mismatch($sformatf("value %h, expected %h (index %0d)",
                                              m_axis_tdata[31:0], oldest.value, oldest.index));
                if (m_axis_tdata[47:32] !== oldest.index)
                    report_mismatch($sformatf("index %0d, expected %0d",
                                              m_axis_tdata[47:32], oldest.index));
                if (m_axis_tlast !== oldest.last)
                    report_mismatch($sformatf("final flag %b, expected %b (index %0d)",
                                              m_axis_tlast, oldest.last, oldest.index));
            end
        end
    end

    // Reset values: sum, within-row, one by one, unit scale.
    task automatic test_reset_state();
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        wait_until_idle();
    endtask

    // Every operation on a two-element row holding both extremes.
    task automatic test_each_operation();
        write_register(tar_pkg::CFG_ROWS, 32'd1);
        write_register(tar_pkg::CFG_COLS, 32'd2);
        write_register(tar_pkg::CFG_SCALE, 32'd1);
        for (int code = tar_pkg::OP_MAX; code <= tar_pkg::OP_L1; code++)
        begin
            write_register(tar_pkg::CFG_OP, 32'(code));
            send_sample(32'h8000_0000);
            send_sample(32'h7FFF_FFFF);
            wait_until_idle();
        end
    endtask

    // Across-rows layout with a negative scale, restarted part way through.
    task automatic test_column_layout();
        write_register(tar_pkg::CFG_LAYOUT, 32'(tar_pkg::LAYOUT_COL));
        write_register(tar_pkg::CFG_ROWS, 32'd2);
        write_register(tar_pkg::CFG_OP, 32'(tar_pkg::OP_SUM));
        write_register(tar_pkg::CFG_SCALE, 32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'd5);
        wait_until_idle();
        write_register(tar_pkg::CFG_COLS, 32'd2);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'd1);
        wait_until_idle();
    endtask

    // Zero sizes count as one, and spare op codes act as a sum.
    task automatic test_size_corners();
        write_register(tar_pkg::CFG_LAYOUT, 32'(tar_pkg::LAYOUT_ROW));
        write_register(tar_pkg::CFG_ROWS, 32'd0);
        write_register(tar_pkg::CFG_COLS, 32'd0);
        write_register(tar_pkg::CFG_OP, 32'(OP_SPARE_FIRST));
        send_sample(32'h8000_0000);
        wait_until_idle();
        write_register(tar_pkg::CFG_OP, 32'(OP_SPARE_LAST));
        send_sample(32'h7FFF_FFFF);
        wait_until_idle();
    endtask

    // The largest row count, left unfinished and restarted by a scale write.
    task automatic test_restart_on_write();
        write_register(tar_pkg::CFG_OP, 32'(tar_pkg::OP_MAX));
        write_register(tar_pkg::CFG_ROWS, 32'hFFFF);
        write_register(tar_pkg::CFG_COLS, 32'd1);
        write_register(tar_pkg::CFG_SCALE, 32'h7FFF_FFFF);
        send_sample(32'd3);
        send_sample(32'h8000_0000);
        wait_until_idle();
        write_register(tar_pkg::CFG_SCALE, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        wait_until_idle();
    endtask

    // Widest matrix: a column count above the limit, one result per column up to the last.
    task automatic test_wide_matrix();
        write_register(tar_pkg::CFG_OP, 32'($urandom_range(tar_pkg::OP_MAX, tar_pkg::OP_L1)));
        write_register(tar_pkg::CFG_LAYOUT, 32'(tar_pkg::LAYOUT_COL));
        write_register(tar_pkg::CFG_ROWS, 32'd1);
        write_register(tar_pkg::CFG_COLS, 32'd2047);
        write_register(tar_pkg::CFG_SCALE, pick_scale());
        repeat (MAX_COLS) send_sample(pick_sample());
        wait_until_idle();
    endtask

    // Random settings per phase; mostly whole matrices, some cut short.
    task automatic test_random_matrices();
        int target;
        int size;
        int count;
        bit first;
        target = items_sent + RANDOM_ITEMS;
        first = 1'b1;
        while (items_sent < target)
        begin
            if (first || $urandom_range(0, 1))
                write_register(tar_pkg::CFG_OP, ($urandom_range(0, 9) == 0)
                               ? 32'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST))
                               : 32'($urandom_range(tar_pkg::OP_MAX, tar_pkg::OP_L1)));
            if (first || $urandom_range(0, 1))
                write_register(tar_pkg::CFG_LAYOUT, 32'($urandom_range(0, 1)));
            if (first || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 19))
                    0:       write_register(tar_pkg::CFG_ROWS, 32'd0);
                    1:       write_register(tar_pkg::CFG_ROWS, 32'($urandom_range(60000, 65535)));
                    2, 3, 4: write_register(tar_pkg::CFG_ROWS, 32'($urandom_range(7, 16)));
                    default: write_register(tar_pkg::CFG_ROWS, 32'($urandom_range(1, 6)));
                endcase
            end
            if (first || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 19))
                    0:       write_register(tar_pkg::CFG_COLS, 32'd0);
                    1:       write_register(tar_pkg::CFG_COLS, 32'($urandom_range(41, 100)));
                    2, 3, 4: write_register(tar_pkg::CFG_COLS, 32'($urandom_range(13, 40)));
                    default: write_register(tar_pkg::CFG_COLS, 32'($urandom_range(1, 12)));
                endcase
            end
            if (first || $urandom_range(0, 1))
                write_register(tar_pkg::CFG_SCALE, pick_scale());
            // Writes to unused indexes must leave the matrix position alone.
            if ($urandom_range(0, 9) == 0)
                write_register(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
            first = 1'b0;

            size = eff_rows() * eff_cols();
            if (size > 400)
                count = $urandom_range(1, 60);
            else if ($urandom_range(0, 6) == 0)
                count = $urandom_range(1, size);
            else
                count = size * $urandom_range(1, 3);
            repeat (count) send_sample(pick_sample());
            wait_until_idle();
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_each_operation();
        test_column_layout();
        test_size_corners();
        test_restart_on_write();
        test_wide_matrix();
        test_random_matrices();

        wait_until_idle();
        repeat (20) @(posedge clk);
        if (pending_reductions.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_reductions.size()));
        $display("Sent %0d samples and checked %0d results through %0d register writes,",
                 items_sent, results_seen, register_writes);
        $display("covering all reductions, both layouts, size corners and restarts.");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/tar_pkg.sv
rtl/tensor_axis_reducer_core.sv
bench/tb_tensor_axis_reducer_core.sv
